>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the rank order window filter.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, masked during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rowf_pkg.sv
// Package of the rank order window filter: field widths, codes, register indexes,
// sequencer states and the control structures between the sequencer and the sorter.
// Depends on nothing.
`timescale 1ns / 1ps

package rowf_pkg;

   localparam int PIX_W      = 8;
   localparam int COORD_W    = 8;
   localparam int DIM_W      = 9;
   localparam int TRIM_W     = 4;
   localparam int CMD_W      = 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam int DEF_MAX_WIDTH   = 256;
   localparam int DEF_MAX_HEIGHT  = 256;
   localparam int DEF_WINDOW_SIDE = 5;

   localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 9'd256;
   localparam logic [TRIM_W-1:0] RST_TRIM         = 4'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM         = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 1'b0,
      CMD_FILTER = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_ROW,
      ST_MOD_COL,
      ST_BACKUP,
      ST_FETCH,
      ST_LOAD,
      ST_SEARCH,
      ST_SUM,
      ST_DIVIDE
   } rowf_state_type;

   typedef struct packed {
      logic clear;
      logic load_key;
      logic search;
      logic sum_init;
      logic sum_step;
   } sort_ctrl_type;

   typedef struct packed {
      logic found;
      logic last;
      logic sum_last;
   } sort_stat_type;

endpackage

>>> rtl/rank_order_window_filter_5x5_top.sv
// Top level of the rank order window filter: frame store, sequencer, coordinate wrap.
// Depends on rowf_pkg, rowf_ram, rowf_div and rowf_sort.
// A transaction is accepted at a rising edge with start high and busy low.
// A load transaction writes req_pixel_in at (req_row, req_col);
// busy stays low and no response follows, so loads may stream every cycle.
// A filter transaction raises busy from the next cycle. The block wraps the
// centre into the plane with the bit-serial divider (skipped when already
// inside), reads the 5x5 window from the single-port frame store one entry per
// insertion, inserts each value into a sorted store by binary search through one
// comparator, sums the kept ranks and divides by their count on the same divider.
// Busy covers, in order: the wrap of each coordinate that needs it, the step back
// to the window corner, the first read, a key load and a binary search for each
// window value, a summing step for each kept value, and the mean division.
// The result appears on rsp_filtered for exactly one cycle with rsp_valid high,
// in the same cycle that busy falls; the receiver cannot stall it.
// Configuration writes via csr_we are taken at once while busy is low.
// Reset restores the register defaults and idles the sequencer; the frame
// store is not cleared and must be loaded before it is filtered.
`timescale 1ns / 1ps

module rank_order_window_filter_5x5_top #(
   parameter int MAX_WIDTH   = rowf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = rowf_pkg::DEF_MAX_HEIGHT,
   parameter int WINDOW_SIDE = rowf_pkg::DEF_WINDOW_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [rowf_pkg::CMD_W-1:0]       req_command,
   input  logic [rowf_pkg::COORD_W-1:0]     req_row,
   input  logic [rowf_pkg::COORD_W-1:0]     req_col,
   input  logic [rowf_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                             rsp_valid,
   output logic [rowf_pkg::PIX_W-1:0]       rsp_filtered,
   input  logic                             csr_we,
   input  logic [rowf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rowf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rowf_pkg::*;

   localparam int WIN_CELLS = WINDOW_SIDE * WINDOW_SIDE;
   localparam int WIN_HALF  = WINDOW_SIDE / 2;
   localparam int TRIM_CAP  = (WIN_CELLS - 1) / 2;
   localparam int ADDR_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int CNT_W     = $clog2(WIN_CELLS + 1);
   localparam int SUM_W     = $clog2(WIN_CELLS * 255 + 1);
   localparam int COL_W     = $clog2(WINDOW_SIDE);
   localparam int HALF_W    = $clog2(WIN_HALF + 1);
   localparam int DIM_MAX   = (1 << DIM_W) - 1;
   localparam int W_CAP     = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
   localparam int H_CAP     = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;

   function automatic logic [DIM_W-1:0] wrap_inc(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] d);
      return (v + 1'b1 == d) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [DIM_W-1:0] wrap_dec(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] d);
      return (v == '0) ? d - 1'b1 : v - 1'b1;
   endfunction

   rowf_state_type state_ff, state_in;

   logic [DIM_W-1:0]  csr_width_ff;
   logic [DIM_W-1:0]  csr_height_ff;
   logic [TRIM_W-1:0] csr_trim_ff;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [CNT_W-1:0]  t_eff, kept;

   logic [DIM_W-1:0]  pr_ff, pr_in;
   logic [DIM_W-1:0]  pc_ff, pc_in;
   logic [DIM_W-1:0]  pc_start_ff, pc_start_in;
   logic [HALF_W-1:0] back_cnt_ff, back_cnt_in;
   logic [COL_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [CNT_W-1:0]  fcnt_ff, fcnt_in;
   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_filtered_ff;

   logic              accept, load_acc, filt_acc, load_in_range;
   logic              row_need, col_need, issue;
   logic [ADDR_W-1:0] load_addr, read_addr;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_rdata;

   sort_ctrl_type     sort_ctrl;
   sort_stat_type     sort_stat;
   logic [SUM_W-1:0]  sort_sum;

   logic              div_start, div_busy, div_done;
   logic [SUM_W-1:0]  div_dividend, div_quotient;
   logic [DIM_W-1:0]  div_divisor, div_remainder;

   assign accept   = start && !busy;
   assign load_acc = accept && (req_command == CMD_LOAD);
   assign filt_acc = accept && (req_command == CMD_FILTER);
   assign busy     = (state_ff != ST_IDLE);

   assign w_eff = (csr_width_ff == '0) ? DIM_W'(1) :
                  (csr_width_ff > DIM_W'(W_CAP)) ? DIM_W'(W_CAP) : csr_width_ff;
   assign h_eff = (csr_height_ff == '0) ? DIM_W'(1) :
                  (csr_height_ff > DIM_W'(H_CAP)) ? DIM_W'(H_CAP) : csr_height_ff;
   assign t_eff = (CNT_W'(csr_trim_ff) > CNT_W'(TRIM_CAP)) ? CNT_W'(TRIM_CAP)
                                                            : CNT_W'(csr_trim_ff);
   assign kept  = CNT_W'(WIN_CELLS) - (t_eff << 1);

   assign row_need = (pr_ff >= h_eff);
   assign col_need = (pc_ff >= w_eff);

   assign load_in_range = (32'(req_row) < MAX_HEIGHT) && (32'(req_col) < MAX_WIDTH);
   assign load_addr     = ADDR_W'(32'(req_row) * MAX_WIDTH + 32'(req_col));
   assign read_addr     = ADDR_W'(32'(pr_ff) * MAX_WIDTH + 32'(pc_ff));
   assign ram_we        = load_acc && load_in_range;
   assign ram_addr      = ram_we ? load_addr : read_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= RST_IMAGE_WIDTH;
         csr_height_ff <= RST_IMAGE_HEIGHT;
         csr_trim_ff   <= RST_TRIM;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  csr_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: csr_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_TRIM:         csr_trim_ff   <= csr_wdata[TRIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (filt_acc) begin
               state_in = ST_MOD_ROW;
            end
         end
         ST_MOD_ROW: begin
            if (!row_need) begin
               state_in = ST_MOD_COL;
            end
         end
         ST_MOD_COL: begin
            if (!col_need) begin
               state_in = ST_BACKUP;
            end
         end
         ST_BACKUP: begin
            if (back_cnt_ff == HALF_W'(WIN_HALF - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (sort_stat.found) begin
               state_in = sort_stat.last ? ST_SUM : ST_LOAD;
            end
         end
         ST_SUM: begin
            if (sort_stat.sum_last) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sort_ctrl    = '0;
      div_start    = 1'b0;
      div_dividend = SUM_W'(pr_ff);
      div_divisor  = h_eff;
      issue        = 1'b0;
      unique case (state_ff)
         ST_IDLE: sort_ctrl.clear = filt_acc;
         ST_MOD_ROW: begin
            div_start = row_need && !div_busy && !div_done;
         end
         ST_MOD_COL: begin
            div_dividend = SUM_W'(pc_ff);
            div_divisor  = w_eff;
            div_start    = col_need && !div_busy && !div_done;
         end
         ST_BACKUP: ;
         ST_FETCH: issue = 1'b1;
         ST_LOAD: begin
            sort_ctrl.load_key = 1'b1;
            issue              = (fcnt_ff < CNT_W'(WIN_CELLS));
         end
         ST_SEARCH: begin
            sort_ctrl.search   = 1'b1;
            sort_ctrl.sum_init = sort_stat.found && sort_stat.last;
         end
         ST_SUM: sort_ctrl.sum_step = 1'b1;
         ST_DIVIDE: begin
            div_dividend = sort_sum;
            div_divisor  = DIM_W'(kept);
            div_start    = !div_busy && !div_done;
         end
         default: ;
      endcase
   end

   always_comb begin
      pr_in       = pr_ff;
      pc_in       = pc_ff;
      pc_start_in = pc_start_ff;
      back_cnt_in = back_cnt_ff;
      col_cnt_in  = col_cnt_ff;
      fcnt_in     = fcnt_ff;
      if (filt_acc) begin
         pr_in       = DIM_W'(req_row);
         pc_in       = DIM_W'(req_col);
         back_cnt_in = '0;
         col_cnt_in  = '0;
         fcnt_in     = '0;
      end
      if (state_ff == ST_MOD_ROW && div_done) begin
         pr_in = div_remainder;
      end
      if (state_ff == ST_MOD_COL && div_done) begin
         pc_in = div_remainder;
      end
      if (state_ff == ST_BACKUP) begin
         pr_in       = wrap_dec(pr_ff, h_eff);
         pc_in       = wrap_dec(pc_ff, w_eff);
         pc_start_in = wrap_dec(pc_ff, w_eff);
         back_cnt_in = back_cnt_ff + 1'b1;
      end
      if (issue) begin
         fcnt_in = fcnt_ff + 1'b1;
         if (col_cnt_ff == COL_W'(WINDOW_SIDE - 1)) begin
            col_cnt_in = '0;
            pc_in      = pc_start_ff;
            pr_in      = wrap_inc(pr_ff, h_eff);
         end else begin
            col_cnt_in = col_cnt_ff + 1'b1;
            pc_in      = wrap_inc(pc_ff, w_eff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_DIVIDE) && div_done;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff       <= pr_in;
      pc_ff       <= pc_in;
      pc_start_ff <= pc_start_in;
      back_cnt_ff <= back_cnt_in;
      col_cnt_ff  <= col_cnt_in;
      fcnt_ff     <= fcnt_in;
      if (state_ff == ST_DIVIDE && div_done) begin
         rsp_filtered_ff <= div_quotient[PIX_W-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   rowf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .re    (issue),
      .addr  (ram_addr),
      .wdata (req_pixel_in),
      .rdata (ram_rdata)
   );

   rowf_sort #(
      .WINDOW_SIDE (WINDOW_SIDE)
   ) u_sort (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (sort_ctrl),
      .sample (ram_rdata),
      .trim   (t_eff),
      .stat   (sort_stat),
      .sum    (sort_sum)
   );

   rowf_div #(
      .DVD_W (SUM_W),
      .DVS_W (DIM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

endmodule

>>> rtl/rowf_ram.sv
// Generic single-port RAM with registered read data, used for the frame store.
// Depends on nothing.
`timescale 1ns / 1ps

module rowf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/rowf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by the
// coordinate wrap and the final mean. Depends on nothing.
`timescale 1ns / 1ps

module rowf_div #(
   parameter int DVD_W = 13,
   parameter int DVS_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/rowf_sort.sv
// Sorted window store with binary-search insertion through one comparator,
// and the accumulator that sums the kept ranks. Depends on rowf_pkg.
`timescale 1ns / 1ps

module rowf_sort #(
   parameter int WINDOW_SIDE = rowf_pkg::DEF_WINDOW_SIDE,
   localparam int WIN_CELLS = WINDOW_SIDE * WINDOW_SIDE,
   localparam int CNT_W = $clog2(WIN_CELLS + 1),
   localparam int SUM_W = $clog2(WIN_CELLS * 255 + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rowf_pkg::sort_ctrl_type     ctrl,
   input  logic [rowf_pkg::PIX_W-1:0]  sample,
   input  logic [CNT_W-1:0]            trim,
   output rowf_pkg::sort_stat_type     stat,
   output logic [SUM_W-1:0]            sum
);

   import rowf_pkg::*;

   localparam int IDX_W = $clog2(WIN_CELLS);
   localparam int MID_W = CNT_W + 1;

   logic [PIX_W-1:0] vals_ff [WIN_CELLS];
   logic [PIX_W-1:0] vals_in [WIN_CELLS];
   logic [PIX_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [MID_W-1:0] mid_sum;
   logic [IDX_W-1:0] mid;
   logic [IDX_W-1:0] rd_idx;
   logic [PIX_W-1:0] rd_val;
   logic             found;
   logic             less;

   assign mid_sum = MID_W'(lo_ff) + MID_W'(hi_ff);
   assign mid     = mid_sum[IDX_W:1];
   assign found   = (lo_ff == hi_ff);
   assign rd_idx  = ctrl.sum_step ? idx_ff : mid;
   assign rd_val  = vals_ff[rd_idx];
   assign less    = key_ff < rd_val;

   always_comb begin
      vals_in = vals_ff;
      key_in  = key_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      n_in    = n_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         n_in = '0;
      end
      if (ctrl.load_key) begin
         key_in = sample;
         lo_in  = '0;
         hi_in  = n_ff;
      end
      if (ctrl.search) begin
         if (found) begin
            if (lo_ff == '0) begin
               vals_in[0] = key_ff;
            end
            for (int i = 1; i < WIN_CELLS; i++) begin
               if (CNT_W'(i) > lo_ff) begin
                  vals_in[i] = vals_ff[i-1];
               end else if (CNT_W'(i) == lo_ff) begin
                  vals_in[i] = key_ff;
               end
            end
            n_in = n_ff + 1'b1;
         end else if (less) begin
            hi_in = CNT_W'(mid);
         end else begin
            lo_in = CNT_W'(mid) + 1'b1;
         end
      end
      if (ctrl.sum_init) begin
         idx_in = IDX_W'(trim);
         acc_in = '0;
      end
      if (ctrl.sum_step) begin
         acc_in = acc_ff + SUM_W'(rd_val);
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff  <= '0;
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         n_ff  <= n_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      vals_ff <= vals_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
   end

   assign stat.found    = found;
   assign stat.last     = (n_ff == CNT_W'(WIN_CELLS - 1));
   assign stat.sum_last = (CNT_W'(idx_ff) == CNT_W'(WIN_CELLS) - trim - 1'b1);
   assign sum           = acc_ff;

endmodule

>>> rtl/rowf_checker.sv
// Port-level checker for the rank order window filter, bound to the top level.
// Depends on rowf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rowf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [rowf_pkg::CMD_W-1:0] req_command,
   input logic                       rsp_valid
);

   import rowf_pkg::*;

   `ASSERT_NEXT(a_filter_sets_busy, clock, reset, start && !busy && req_command == CMD_FILTER, busy, "filter transaction did not raise busy")
   `ASSERT_NEXT(a_load_no_response, clock, reset, start && !busy && req_command == CMD_LOAD, !busy && !rsp_valid, "load transaction raised busy or a response")
   `ASSERT_IMPL(a_response_ends_busy, clock, reset, rsp_valid, $past(busy) && !busy, "response without a preceding busy period")
   `ASSERT_IMPL(a_busy_ends_in_response, clock, reset, !$past(reset) && $fell(busy), rsp_valid, "busy fell without a response")

endmodule

bind rank_order_window_filter_5x5_top rowf_checker u_rowf_checker (.*);

>>> verif/rank_order_window_filter_5x5_top_tb.sv
// Self-checking testbench of rank_order_window_filter_5x5_top: directed table, then random
// load and filter transactions over many plane sizes and trims, checked by a trimmed-mean model.
// Depends on rowf_pkg and the RTL of the block; reads no file.
`timescale 1ns / 1ps

module rank_order_window_filter_5x5_top_tb;
   import rowf_pkg::*;

   localparam int WIN_SIDE   = DEF_WINDOW_SIDE;
   localparam int WIN_CELLS  = WIN_SIDE * WIN_SIDE;
   localparam int TRIM_CAP   = (WIN_CELLS - 1) / 2;
   localparam int MIXED_ITEMS = 400;
   localparam int PHASE_ITEMS = 40;
   localparam int DIR_STEPS  = 25;
   localparam int PRESETS    = 9;

   typedef enum logic {
      STEP_ITEM,
      STEP_CSR
   } step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      cmd_type                 cmd;
      logic [COORD_W-1:0]      row;
      logic [COORD_W-1:0]      col;
      logic [PIX_W-1:0]        pix;
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   wdata;
      logic                    typed;
      logic [PIX_W-1:0]        filtered;
   } dir_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CMD_W-1:0]        req_command = '0;
   logic [COORD_W-1:0]      req_row = '0;
   logic [COORD_W-1:0]      req_col = '0;
   logic [PIX_W-1:0]        req_pixel_in = '0;
   logic                    rsp_valid;
   logic [PIX_W-1:0]        rsp_filtered;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   logic [PIX_W-1:0]        plane_copy [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
   bit                      loaded [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
   logic [DIM_W-1:0]        width_reg = RST_IMAGE_WIDTH;
   logic [DIM_W-1:0]        height_reg = RST_IMAGE_HEIGHT;
   logic [TRIM_W-1:0]       trim_reg = RST_TRIM;
   logic [PIX_W-1:0]        pending_filtered [$];
   int                      mismatches = 0;
   int                      idle_pct = 34;
   dir_step_type            dir_table [DIR_STEPS];
   int preset_w [PRESETS] = '{256, 1, 511, 0, 5, 7, 3, 9, 4};
   int preset_h [PRESETS] = '{1, 256, 1, 300, 5, 6, 4, 2, 9};
   int preset_t [PRESETS] = '{0, 12, 15, 3, 6, 1, 13, 10, 2};

   rank_order_window_filter_5x5_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_pixel_in (req_pixel_in),
      .rsp_valid    (rsp_valid),
      .rsp_filtered (rsp_filtered),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int eff_dim(logic [DIM_W-1:0] raw, int limit);
      if (raw == 0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   function automatic logic [PIX_W-1:0] window_trimmed_mean(logic [COORD_W-1:0] row,
                                                            logic [COORD_W-1:0] col);
      int w, h, t, pr, pc, n, j, sum;
      logic [PIX_W-1:0] win [WIN_CELLS];
      logic [PIX_W-1:0] key;
      w = eff_dim(width_reg, DEF_MAX_WIDTH);
      h = eff_dim(height_reg, DEF_MAX_HEIGHT);
      t = (int'(trim_reg) > TRIM_CAP) ? TRIM_CAP : int'(trim_reg);
      n = 0;
      for (int kr = 0; kr < WIN_SIDE; kr++) begin
         pr = (int'(row) % h + WIN_SIDE * h + kr - WIN_SIDE / 2) % h;
         for (int kc = 0; kc < WIN_SIDE; kc++) begin
            pc = (int'(col) % w + WIN_SIDE * w + kc - WIN_SIDE / 2) % w;
            win[n] = plane_copy[pr * DEF_MAX_WIDTH + pc];
            n++;
         end
      end
      for (int i = 1; i < WIN_CELLS; i++) begin
         key = win[i];
         j = i - 1;
         while (j >= 0 && win[j] > key) begin
            win[j + 1] = win[j];
            j--;
         end
         win[j + 1] = key;
      end
      sum = 0;
      for (int i = t; i < WIN_CELLS - t; i++) sum += win[i];
      return PIX_W'(sum / (WIN_CELLS - 2 * t));
   endfunction

   // Presents one transaction and holds it until the block takes it.
   task automatic issue_item(cmd_type cmd, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                             logic [PIX_W-1:0] pix, logic typed, logic [PIX_W-1:0] typed_val);
      int addr;
      addr = int'({row, col});
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_row <= row;
      req_col <= col;
      req_pixel_in <= pix;
      do @(posedge clock); while (busy);
      if (cmd == CMD_LOAD) begin
         plane_copy[addr] = pix;
         loaded[addr] = 1'b1;
      end else begin
         pending_filtered.push_back(typed ? typed_val : window_trimmed_mean(row, col));
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      start <= 1'b0;
      while (pending_filtered.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_IMAGE_WIDTH:  width_reg = data;
         CSR_IMAGE_HEIGHT: height_reg = data;
         CSR_TRIM:         trim_reg = data[TRIM_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_filtered.size() == 0) begin
            $error("filtered: no transaction outstanding, got %0d", rsp_filtered);
            mismatches++;
         end else if (rsp_filtered !== pending_filtered[0]) begin
            $error("filtered: expected %0d, got %0d", pending_filtered[0], rsp_filtered);
            mismatches++;
            void'(pending_filtered.pop_front());
         end else begin
            void'(pending_filtered.pop_front());
         end
      end
   end

   initial begin
      int mixed, phase, w, h, row, col, pix;
      logic [DIM_W-1:0] raw_w, raw_h;
      logic [TRIM_W-1:0] raw_t;
      dir_table = '{
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_IMAGE_WIDTH,  9'd0,   1'b0, 8'd0},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_IMAGE_HEIGHT, 9'd0,   1'b0, 8'd0},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'd12,  1'b0, 8'd0},
         '{STEP_ITEM, CMD_LOAD,   8'd0,   8'd0,   8'd255, CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'd0,   1'b1, 8'd255},
         '{STEP_ITEM, CMD_FILTER, 8'd255, 8'd255, 8'd255, CSR_TRIM,         9'd0,   1'b1, 8'd255},
         '{STEP_ITEM, CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd128, 8'd77,  8'd90,  CSR_TRIM,         9'd0,   1'b1, 8'd0},
         '{STEP_ITEM, CMD_LOAD,   8'd255, 8'd255, 8'd170, CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd1,   8'd254, 8'd0,   CSR_TRIM,         9'd0,   1'b1, 8'd0},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_LOAD,   8'd0,   8'd0,   8'd255, CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd200, 8'd3,   8'd0,   CSR_TRIM,         9'd0,   1'b1, 8'd255},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_IMAGE_WIDTH,  9'd2,   1'b0, 8'd0},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_IMAGE_HEIGHT, 9'd2,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_LOAD,   8'd0,   8'd1,   8'd0,   CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_LOAD,   8'd1,   8'd0,   8'd1,   CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_LOAD,   8'd1,   8'd1,   8'd128, CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'h1FF, 1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd1,   8'd1,   8'd0,   CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'd12,  1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd255, 8'd0,   8'd0,   CSR_TRIM,         9'd0,   1'b0, 8'd0},
         '{STEP_CSR,  CMD_LOAD,   8'd0,   8'd0,   8'd0,   CSR_TRIM,         9'd7,   1'b0, 8'd0},
         '{STEP_ITEM, CMD_FILTER, 8'd0,   8'd1,   8'd0,   CSR_TRIM,         9'd0,   1'b0, 8'd0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == STEP_CSR)
            write_csr(dir_table[i].index, dir_table[i].wdata);
         else
            issue_item(dir_table[i].cmd, dir_table[i].row, dir_table[i].col,
                       dir_table[i].pix, dir_table[i].typed, dir_table[i].filtered);
      end

      mixed = 0;
      phase = 0;
      while (mixed < MIXED_ITEMS) begin
         if (phase < PRESETS) begin
            raw_w = DIM_W'(preset_w[phase]);
            raw_h = DIM_W'(preset_h[phase]);
            raw_t = TRIM_W'(preset_t[phase]);
         end else begin
            raw_w = DIM_W'($urandom_range(0, 12));
            raw_h = DIM_W'($urandom_range(0, 12));
            raw_t = TRIM_W'($urandom_range(0, 15));
         end
         phase++;
         write_csr(CSR_IMAGE_WIDTH, raw_w);
         write_csr(CSR_IMAGE_HEIGHT, raw_h);
         write_csr(CSR_TRIM, CSR_DATA_W'(raw_t));
         w = eff_dim(width_reg, DEF_MAX_WIDTH);
         h = eff_dim(height_reg, DEF_MAX_HEIGHT);

         // Every entry of the plane in use must hold a value before it is filtered.
         for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
               if (!loaded[r * DEF_MAX_WIDTH + c])
                  issue_item(CMD_LOAD, COORD_W'(r), COORD_W'(c),
                             PIX_W'($urandom_range(0, 255)), 1'b0, '0);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            idle_pct = (mixed < MIXED_ITEMS / 3) ? 34 : (mixed < 2 * MIXED_ITEMS / 3) ? 87 : 0;
            if ($urandom_range(0, 1) == 1) begin
               row = $urandom_range(0, 255);
               col = $urandom_range(0, 255);
            end else begin
               row = $urandom_range(0, h - 1);
               col = $urandom_range(0, w - 1);
            end
            case ($urandom_range(0, 7))
               0:       pix = 0;
               1:       pix = 255;
               default: pix = $urandom_range(0, 255);
            endcase
            if ($urandom_range(0, 99) < 55)
               issue_item(CMD_FILTER, COORD_W'(row), COORD_W'(col), PIX_W'(pix), 1'b0, '0);
            else
               issue_item(CMD_LOAD, COORD_W'(row), COORD_W'(col), PIX_W'(pix), 1'b0, '0);
            mixed++;
         end
      end

      start <= 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0)
         $display("rank_order_window_filter_5x5_top: match");
      else
         $display("rank_order_window_filter_5x5_top: mismatch");
      $finish;
   end

   initial begin
      #15000000;
      $display("rank_order_window_filter_5x5_top: mismatch");
      $finish;
   end

endmodule
